// File: sv/scgb_pkg.sv
// Shared types and constants for the serial command GPIO bridge.
// No dependencies; every other file except scgb_checker imports this package.
package scgb_pkg;

    localparam int PORT_WIDTH = 8;
    localparam int NUM_PORTS  = 3;

    localparam logic [7:0] CH_0 = 8'h30;
    localparam logic [7:0] CH_E = 8'h45;
    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_L = 8'h4C;
    localparam logic [7:0] CH_B = 8'h42;
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_D = 8'h44;

    typedef enum logic [1:0] {
        PH_CMD  = 2'd0,
        PH_PORT = 2'd1,
        PH_PIN  = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        CMD_ON   = 2'd0,
        CMD_OFF  = 2'd1,
        CMD_READ = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        PORT_B    = 2'd0,
        PORT_C    = 2'd1,
        PORT_D    = 2'd2,
        PORT_NONE = 2'd3
    } t_port;

    typedef enum logic [2:0] {
        CODE_ON      = 3'd0,
        CODE_OFF     = 3'd1,
        CODE_CLOSED  = 3'd2,
        CODE_OPEN    = 3'd3,
        CODE_NO_PORT = 3'd4,
        CODE_UNKNOWN = 3'd5
    } t_code;

    typedef struct packed {
        logic [7:0]                rx;
        logic [NUM_PORTS-1:0][7:0] pins;
    } t_item;

    typedef struct packed {
        t_code                     code;
        logic [NUM_PORTS-1:0][7:0] dir;
        logic [NUM_PORTS-1:0][7:0] drv;
    } t_result;

endpackage

// File: sv/serial_command_gpio_bridge.sv
// Top level of the serial command GPIO bridge: input register, parser, result register.
// Depends on scgb_pkg, scgb_in_stage, scgb_core, scgb_out_stage.
//
//   channel | handshake                | payload
//   in      | i_in_valid / o_in_ready  | i_rx_byte, i_pins_b, i_pins_c, i_pins_d
//   out     | o_out_valid / i_out_ready| o_reply_code, o_dir_b..o_out_d
//
// One word per cycle while no unread reply holds it back; a reply passes the input register, then the result register.
// The input register advances whenever the result register is free or the word
// gives no reply; an unread reply holds the next replying word in place.
// Synchronous active-low reset clears parser state and all port bytes.
module serial_command_gpio_bridge import scgb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_rx_byte,
    input  logic [7:0] i_pins_b,
    input  logic [7:0] i_pins_c,
    input  logic [7:0] i_pins_d,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_reply_code,
    output logic [7:0] o_dir_b,
    output logic [7:0] o_out_b,
    output logic [7:0] o_dir_c,
    output logic [7:0] o_out_c,
    output logic [7:0] o_dir_d,
    output logic [7:0] o_out_d
);

    t_item   in_item, held_item;
    t_result core_result, out_result;
    logic    held_valid, has_result, out_space, fire;

    assign in_item.rx      = i_rx_byte;
    assign in_item.pins[0] = i_pins_b;
    assign in_item.pins[1] = i_pins_c;
    assign in_item.pins[2] = i_pins_d;

    assign fire = held_valid && (!has_result || out_space);

    scgb_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (in_item),
        .o_valid (held_valid),
        .o_item  (held_item),
        .i_take  (fire)
    );

    scgb_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_item       (held_item),
        .o_has_result (has_result),
        .o_result     (core_result)
    );

    scgb_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire && has_result),
        .i_result (core_result),
        .o_space  (out_space),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (out_result)
    );

    assign o_reply_code = out_result.code;
    assign o_dir_b      = out_result.dir[0];
    assign o_out_b      = out_result.drv[0];
    assign o_dir_c      = out_result.dir[1];
    assign o_out_c      = out_result.drv[1];
    assign o_dir_d      = out_result.dir[2];
    assign o_out_d      = out_result.drv[2];

endmodule

// File: sv/scgb_in_stage.sv
// Input register for received words and sampled pin levels.
// Depends on scgb_pkg.
module scgb_in_stage import scgb_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_take
);

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

// File: sv/scgb_core.sv
// Command parser and port byte state: decodes one word per cycle while i_fire is high.
// Depends on scgb_pkg.
module scgb_core import scgb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    output logic    o_has_result,
    output t_result o_result
);

    t_phase r_phase, n_phase;
    t_cmd   r_cmd, n_cmd;
    t_port  r_port, n_port;
    logic [NUM_PORTS-1:0][7:0] r_dir, n_dir;
    logic [NUM_PORTS-1:0][7:0] r_drv, n_drv;

    logic [7:0] pin;
    logic [7:0] mask;
    logic       is_cmd;

    assign is_cmd = (i_item.rx == CH_E) || (i_item.rx == CH_A) || (i_item.rx == CH_L);
    assign pin    = i_item.rx - CH_0;
    assign mask   = (pin < 8'(PORT_WIDTH)) ? (8'd1 << pin) : 8'd0;

    always_comb begin
        n_phase = PH_CMD;
        n_cmd   = r_cmd;
        n_port  = r_port;
        case (r_phase)
            PH_PORT: begin
                n_phase = PH_PIN;
                if (i_item.rx == CH_B) begin
                    n_port = PORT_B;
                end else if (i_item.rx == CH_C) begin
                    n_port = PORT_C;
                end else if (i_item.rx == CH_D) begin
                    n_port = PORT_D;
                end else begin
                    n_port = PORT_NONE;
                end
            end
            PH_PIN: begin
                n_phase = PH_CMD;
            end
            default: begin
                if (is_cmd) begin
                    n_phase = PH_PORT;
                end
                if (i_item.rx == CH_E) begin
                    n_cmd = CMD_ON;
                end else if (i_item.rx == CH_A) begin
                    n_cmd = CMD_OFF;
                end else if (i_item.rx == CH_L) begin
                    n_cmd = CMD_READ;
                end
            end
        endcase
    end

    always_comb begin
        n_dir        = r_dir;
        n_drv        = r_drv;
        o_has_result = 1'b0;
        o_result.code = CODE_UNKNOWN;
        case (r_phase)
            PH_PORT: begin
                o_has_result = 1'b0;
            end
            PH_PIN: begin
                o_has_result  = 1'b1;
                o_result.code = CODE_NO_PORT;
                for (int p = 0; p < NUM_PORTS; p++) begin
                    if (r_port == t_port'(p)) begin
                        case (r_cmd)
                            CMD_ON: begin
                                n_dir[p] = r_dir[p] | mask;
                                n_drv[p] = r_drv[p] | mask;
                                o_result.code = CODE_ON;
                            end
                            CMD_OFF: begin
                                n_dir[p] = r_dir[p] | mask;
                                n_drv[p] = r_drv[p] & ~mask;
                                o_result.code = CODE_OFF;
                            end
                            default: begin
                                n_dir[p] = r_dir[p] & ~mask;
                                n_drv[p] = r_drv[p] | mask;
                                o_result.code = ((i_item.pins[p] & mask) != 8'd0) ?
                                                CODE_OPEN : CODE_CLOSED;
                            end
                        endcase
                    end
                end
            end
            default: begin
                o_has_result = !is_cmd;
            end
        endcase
        o_result.dir = n_dir;
        o_result.drv = n_drv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_CMD;
            r_cmd   <= CMD_ON;
            r_port  <= PORT_B;
            r_dir   <= '0;
            r_drv   <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_cmd   <= n_cmd;
            r_port  <= n_port;
            r_dir   <= n_dir;
            r_drv   <= n_drv;
        end
    end

endmodule

// File: sv/scgb_out_stage.sv
// Result register with valid/ready toward the consumer.
// Depends on scgb_pkg.
module scgb_out_stage import scgb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    output logic    o_space,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_space  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// File: sv/scgb_checker.sv
// Port-level checks for the serial command GPIO bridge, bound to the top level.
// Depends on serial_command_gpio_bridge.
module scgb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [2:0] o_reply_code,
    input logic [7:0] o_dir_b
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("reply pending after reset");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled with free result register");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_reply_code <= 3'd5))
        else $error("reply code out of range");

    a_hold_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_reply_code)
                                           && $stable(o_dir_b)))
        else $error("stalled reply changed");

endmodule

bind serial_command_gpio_bridge scgb_checker u_scgb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_reply_code (o_reply_code),
    .o_dir_b      (o_dir_b)
);
